>>> rtl/ihbp_pkg.sv
// ----------------------------------------------------------------------------
// ihbp_pkg: shared types and constants of the HEX block parser
// Field widths, result and status codes, record type codes and the hex
// character decoder.
// ----------------------------------------------------------------------------
package ihbp_pkg;

	localparam int CH_W     = 8;
	localparam int KIND_W   = 2;
	localparam int ADDR_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int BLEN_W   = 6;
	localparam int STATUS_W = 2;
	localparam int RTYPE_W  = 8;
	localparam int CPOS_W   = 10;

	localparam int BLOCK_BYTES_DEF = 56;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

	// record status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SYNTAX   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNSUPP   = 2'd3;

	// record types
	localparam logic [RTYPE_W-1:0] REC_DATA    = 8'h00;
	localparam logic [RTYPE_W-1:0] REC_EOF     = 8'h01;
	localparam logic [RTYPE_W-1:0] REC_EXT_LIN = 8'h04;

	// characters
	localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CH_W-1:0] CH_0     = 8'h30;
	localparam logic [CH_W-1:0] CH_9     = 8'h39;
	localparam logic [CH_W-1:0] CH_UA    = 8'h41;
	localparam logic [CH_W-1:0] CH_UF    = 8'h46;
	localparam logic [CH_W-1:0] CH_LA    = 8'h61;
	localparam logic [CH_W-1:0] CH_LF    = 8'h66;

	typedef enum logic [2:0] {
		PH_WAIT   = 3'b001,
		PH_RECORD = 3'b010,
		PH_HALT   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ADDR_W-1:0]   address;
		logic [BYTE_W-1:0]   byte_value;
		logic [BLEN_W-1:0]   block_length;
		logic [STATUS_W-1:0] status;
		logic [RTYPE_W-1:0]  record_kind;
		logic                halted;
		logic                last;
	} result_t;

	// up to two results made by one character
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(logic [CH_W-1:0] c);
		logic [CH_W-1:0] d;
		logic [4:0]      r;
		r = 5'd0;
		d = '0;
		if (c >= CH_0 && c <= CH_9) begin
			d = c - CH_0;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + 8'd10;
			r = {1'b1, d[3:0]};
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + 8'd10;
			r = {1'b1, d[3:0]};
		end
		return r;
	endfunction

	function automatic result_t mk_res(
		logic [KIND_W-1:0]   kind,
		logic [ADDR_W-1:0]   addr,
		logic [BYTE_W-1:0]   bval,
		logic [BLEN_W-1:0]   blen,
		logic [STATUS_W-1:0] st,
		logic [RTYPE_W-1:0]  rtype
	);
		result_t r;
		r.kind         = kind;
		r.address      = addr;
		r.byte_value   = bval;
		r.block_length = blen;
		r.status       = st;
		r.record_kind  = rtype;
		r.halted       = 1'b0;
		r.last         = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/ihbp_char_if.sv
// ----------------------------------------------------------------------------
// ihbp_char_if: character channel
// Valid/ready channel carrying one text character per item.
// ----------------------------------------------------------------------------
interface ihbp_char_if;
	import ihbp_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

>>> rtl/ihbp_result_if.sv
// ----------------------------------------------------------------------------
// ihbp_result_if: result channel
// Valid/ready channel carrying one parser result per item.
// ----------------------------------------------------------------------------
interface ihbp_result_if;
	import ihbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [ADDR_W-1:0]   address;
	logic [BYTE_W-1:0]   byte_value;
	logic [BLEN_W-1:0]   block_length;
	logic [STATUS_W-1:0] status;
	logic [RTYPE_W-1:0]  record_kind;
	logic                halted;
	logic                last;

	modport source (output valid, output kind, output address, output byte_value,
		output block_length, output status, output record_kind, output halted,
		output last, input ready);
	modport sink   (input valid, input kind, input address, input byte_value,
		input block_length, input status, input record_kind, input halted,
		input last, output ready);
endinterface

>>> rtl/ihbp_parser.sv
// ----------------------------------------------------------------------------
// ihbp_parser: record field parser and block grouper
// Consumes one registered character per advance, updates record and block
// state, and produces up to two results.
// ----------------------------------------------------------------------------
module ihbp_parser #(
	parameter int BLOCK_BYTES = ihbp_pkg::BLOCK_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [ihbp_pkg::CH_W-1:0] ch_s1,
	output ihbp_pkg::push_t           push,
	output logic                      halted
);
	import ihbp_pkg::*;

	phase_t              phase_q, phase_n;
	logic [CPOS_W-1:0]   cpos_q, cpos_n;
	logic [7:0]          len_q, len_n;
	logic [15:0]         addr_lo_q, addr_lo_n;
	logic [RTYPE_W-1:0]  type_q, type_n;
	logic [7:0]          sum_q, sum_n;
	logic [3:0]          nib_hi_q, nib_hi_n;
	logic [15:0]         pend_q, pend_n;
	logic [15:0]         addr_up_q, addr_up_n;
	logic [ADDR_W-1:0]   next_q, next_n;
	logic [ADDR_W-1:0]   origin_q, origin_n;
	logic [BLEN_W-1:0]   fill_q, fill_n;

	logic [4:0]          hex;
	logic [7:0]          bval;
	logic [CPOS_W-2:0]   k;
	logic                rec_end;
	logic [ADDR_W-1:0]   jump_addr;
	logic [BLEN_W-1:0]   fill_inc;
	logic                full;
	logic [STATUS_W-1:0] st;
	result_t             slot0, slot1;
	logic [1:0]          n_res;

	assign hex       = hex_decode(ch_s1);
	assign bval      = {nib_hi_q, hex[3:0]};
	assign k         = cpos_q[CPOS_W-1:1];
	assign rec_end   = {1'b0, k} >= (CPOS_W'(4) + CPOS_W'(len_q));
	assign jump_addr = {addr_up_q, addr_lo_q};
	assign fill_inc  = fill_q + BLEN_W'(1);
	assign full      = fill_inc >= BLEN_W'(BLOCK_BYTES);

	always_comb begin
		phase_n   = phase_q;
		cpos_n    = cpos_q;
		len_n     = len_q;
		addr_lo_n = addr_lo_q;
		type_n    = type_q;
		sum_n     = sum_q;
		nib_hi_n  = nib_hi_q;
		pend_n    = pend_q;
		addr_up_n = addr_up_q;
		next_n    = next_q;
		origin_n  = origin_q;
		fill_n    = fill_q;
		slot0     = '0;
		slot1     = '0;
		n_res     = 2'd0;
		st        = ST_OK;
		if (advance) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (ch_s1 == CH_COLON) begin
						phase_n   = PH_RECORD;
						cpos_n    = '0;
						len_n     = '0;
						addr_lo_n = '0;
						type_n    = '0;
						sum_n     = '0;
						nib_hi_n  = '0;
						pend_n    = '0;
					end
				end
				PH_RECORD: begin
					if (!hex[4]) begin
						phase_n = PH_HALT;
						slot0   = mk_res(KIND_STATUS, '0, '0, '0, ST_SYNTAX, type_q);
						n_res   = 2'd1;
					end else if (!cpos_q[0]) begin
						nib_hi_n = hex[3:0];
						cpos_n   = cpos_q + CPOS_W'(1);
					end else begin
						cpos_n = cpos_q + CPOS_W'(1);
						sum_n  = sum_q + bval;
						if (k == '0) begin
							len_n = bval;
						end else if (k == (CPOS_W-1)'(1)) begin
							addr_lo_n = {bval, 8'h00};
						end else if (k == (CPOS_W-1)'(2)) begin
							addr_lo_n = {addr_lo_q[15:8], bval};
						end else if (k == (CPOS_W-1)'(3)) begin
							type_n = bval;
							// address jump closes the open block
							if (bval == REC_DATA && jump_addr != next_q) begin
								next_n   = jump_addr;
								origin_n = jump_addr;
								fill_n   = '0;
								if (fill_q != '0) begin
									slot0 = mk_res(KIND_CLOSE, origin_q, '0, fill_q, ST_OK,
										bval);
									n_res = 2'd1;
								end
							end
						end else if (!rec_end) begin
							if (type_q == REC_DATA) begin
								slot0  = mk_res(KIND_DATA, next_q, bval, '0, ST_OK, type_q);
								next_n = next_q + ADDR_W'(1);
								if (full || next_q == '1) begin
									slot1    = mk_res(KIND_CLOSE, origin_q, '0, fill_inc, ST_OK,
										type_q);
									n_res    = 2'd2;
									fill_n   = '0;
									origin_n = next_q + ADDR_W'(1);
								end else begin
									n_res  = 2'd1;
									fill_n = fill_inc;
								end
							end else if (type_q == REC_EXT_LIN && k < (CPOS_W-1)'(6)) begin
								pend_n = {pend_q[7:0], bval};
							end
						end else begin
							// checksum digit: finish the record
							if (sum_n != 8'h00) begin
								st = ST_CHECKSUM;
							end else if (type_q == REC_DATA) begin
								st = ST_OK;
							end else if (type_q == REC_EOF) begin
								origin_n = next_q;
								fill_n   = '0;
								if (fill_q != '0) begin
									slot0 = mk_res(KIND_CLOSE, origin_q, '0, fill_q, ST_OK,
										type_q);
									n_res = 2'd1;
								end
							end else if (type_q == REC_EXT_LIN) begin
								if (len_q < 8'd2) begin
									st = ST_SYNTAX;
								end else begin
									addr_up_n = pend_q;
									next_n    = {pend_q, 16'h0000};
									origin_n  = {pend_q, 16'h0000};
									fill_n    = '0;
									if (fill_q != '0) begin
										slot0 = mk_res(KIND_CLOSE, origin_q, '0, fill_q, ST_OK,
											type_q);
										n_res = 2'd1;
									end
								end
							end else begin
								st = ST_UNSUPP;
							end
							phase_n = (st != ST_OK || type_q == REC_EOF) ? PH_HALT : PH_WAIT;
							if (n_res == 2'd1) begin
								slot1 = mk_res(KIND_STATUS, '0, '0, '0, st, type_q);
								n_res = 2'd2;
							end else begin
								slot0 = mk_res(KIND_STATUS, '0, '0, '0, st, type_q);
								n_res = 2'd1;
							end
						end
					end
				end
				PH_HALT: begin
				end
				default: begin
					phase_n = PH_HALT;
				end
			endcase
		end
	end

	always_comb begin
		push          = '0;
		push.count    = n_res;
		push.r0       = slot0;
		push.r1       = slot1;
		push.r0.halted = (phase_n == PH_HALT);
		push.r1.halted = (phase_n == PH_HALT);
		push.r0.last   = (n_res == 2'd1);
		push.r1.last   = 1'b1;
	end

	assign halted = (phase_q == PH_HALT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			cpos_q    <= '0;
			len_q     <= '0;
			addr_lo_q <= '0;
			type_q    <= '0;
			sum_q     <= '0;
			nib_hi_q  <= '0;
			pend_q    <= '0;
			addr_up_q <= '0;
			next_q    <= '0;
			origin_q  <= '0;
			fill_q    <= '0;
		end else begin
			phase_q   <= phase_n;
			cpos_q    <= cpos_n;
			len_q     <= len_n;
			addr_lo_q <= addr_lo_n;
			type_q    <= type_n;
			sum_q     <= sum_n;
			nib_hi_q  <= nib_hi_n;
			pend_q    <= pend_n;
			addr_up_q <= addr_up_n;
			next_q    <= next_n;
			origin_q  <= origin_n;
			fill_q    <= fill_n;
		end
	end

endmodule

>>> rtl/ihbp_result_fifo.sv
// ----------------------------------------------------------------------------
// ihbp_result_fifo: result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module ihbp_result_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ihbp_pkg::push_t                     push,
	input  logic                                pop,
	output ihbp_pkg::result_t                   head,
	output logic                                head_valid,
	output logic [ihbp_pkg::FIFO_CNT_W-1:0]     count
);
	import ihbp_pkg::*;

	result_t               mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign do_pop     = pop && (cnt_q != '0);
	assign head       = mem[rd_q];
	assign head_valid = (cnt_q != '0);
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + FIFO_PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_PTR_W'(push.count);
			rd_q  <= rd_q + FIFO_PTR_W'(do_pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(do_pop);
		end
	end

endmodule

>>> rtl/intel_hex_block_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_block_parser: HEX text record parser with block grouping
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+----------
//   chars    | in  | ch                                        | valid/ready
//   results  | out | kind, address, byte_value, block_length,  | valid/ready
//            |     | status, record_kind, halted, last         |
//
// One character is taken per cycle while the queue has room; it is held in the
// input register, then the parser updates its state and pushes zero, one or two
// results into a four-entry result queue, whose head drives the output. The
// queue hands out one result at a time while the receiver is ready, so a
// character that makes two results sends them out as two items. Input stalls
// only while the queue holds more than two results. Reset clears all control
// state at once; the held character and the queue storage are not reset.
// ----------------------------------------------------------------------------
module intel_hex_block_parser #(
	parameter int BLOCK_BYTES = ihbp_pkg::BLOCK_BYTES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ihbp_char_if.sink    chars,
	ihbp_result_if.source results
);
	import ihbp_pkg::*;

	logic                  valid_s1;
	logic [CH_W-1:0]       ch_s1;
	logic                  advance;
	push_t                 push;
	logic                  core_halted;
	result_t               head;
	logic                  head_valid;
	logic [FIFO_CNT_W-1:0] fifo_cnt;

	// advance the held character only when the queue has room for two results
	assign advance     = valid_s1 && (fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign chars.ready = !valid_s1 || advance;

	// input register: hold the character until the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1 <= chars.ch;
		end
	end

	ihbp_parser #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.ch_s1  (ch_s1),
		.push   (push),
		.halted (core_halted)
	);

	ihbp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (results.ready),
		.head      (head),
		.head_valid(head_valid),
		.count     (fifo_cnt)
	);

	// drive the result channel from the queue head
	assign results.valid        = head_valid;
	assign results.kind         = head.kind;
	assign results.address      = head.address;
	assign results.byte_value   = head.byte_value;
	assign results.block_length = head.block_length;
	assign results.status       = head.status;
	assign results.record_kind  = head.record_kind;
	assign results.halted       = head.halted;
	assign results.last         = head.last;

`ifndef NO_ASSERTIONS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		core_halted |=> core_halted)
		else $error("parser left halt without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		core_halted |-> push.count == 2'd0)
		else $error("halted parser produced a result");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2))
		else $error("results pushed without queue room");
`endif

endmodule
